/* design/sfla_pkg.sv */
// ----------------------------------------------------------------------------
// Segment free list allocator package
// Shared sizes, codes and control bundles for the segment allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int POOL_DEPTH = 64;
  localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int LVL_W      = $clog2(POOL_DEPTH + 1);

  localparam int ACT_W  = 2;
  localparam int SEG_W  = 6;
  localparam int CNT_W  = 7;
  localparam int STAT_W = 2;

  localparam logic [CNT_W-1:0] POOL_SIZE_RST = CNT_W'(64);

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC_ONE  = 2'd0,
    ACT_ALLOC_MANY = 2'd1,
    ACT_FREE       = 2'd2,
    ACT_RESET      = 2'd3
  } sfla_action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_SHORT  = 2'd1,
    ST_DOUBLE = 2'd2,
    ST_RANGE  = 2'd3
  } sfla_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SEND,
    S_PUSH,
    S_EMIT
  } sfla_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] a;
    logic [CNT_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] res;
    logic             borrow;
  } alu_rsp_t;

  typedef struct packed {
    logic             clear_all;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [SEG_W-1:0] wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } stack_ctrl_t;

  typedef struct packed {
    logic             clear_all;
    logic             set_en;
    logic             clr_en;
    logic [IDX_W-1:0] idx;
  } lent_ctrl_t;

endpackage

/* design/segment_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// Segment free list allocator
// LIFO buffer pool handing out segment indices, one result per cycle at most.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per action (allocate one, allocate several, free,
//           reset pool). in_stall stays high while an action is in progress.
//   out_* : result transactions; a nonzero allocate several that succeeds
//           gives one per segment, out_last on the final; any other gives one.
//   cfg_* : pool_size write, always ready; it takes effect at the next reset
//           pool action. Write it only while the block is idle.
// Sequencing: S_EVAL checks each accepted action; results go out from
//   S_SEND (granted allocations) or S_EMIT; a free that succeeds first
//   pushes in S_PUSH. Allocate several delivers its count results back
//   to back while out_stall is low. A new input transaction is accepted
//   the cycle after the last result is loaded into the output register.
//   Unless out_stall holds the output, the sequencer steps one stack read
//   per cycle through the single registered read port of the free stack.
// Reset refills the stack with indices 0 to POOL_DEPTH-1 at once (no sweep)
// and clears all lent marks. While out_stall is high and a result is held,
// the output register holds it and the sequencer waits; no result is dropped.
// ----------------------------------------------------------------------------
module segment_free_list_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sfla_pkg::ACT_W-1:0]   in_action,
  input  logic [sfla_pkg::CNT_W-1:0]   in_count,
  input  logic [sfla_pkg::SEG_W-1:0]   in_segment,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sfla_pkg::SEG_W-1:0]   out_segment_out,
  output logic                         out_segment_valid,
  output logic [sfla_pkg::STAT_W-1:0]  out_status,
  output logic                         out_last,
  output logic [sfla_pkg::CNT_W-1:0]   out_free_count,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sfla_pkg::CNT_W-1:0]   cfg_pool_size
);
  import sfla_pkg::*;

  sfla_state_t      state_r, state_nxt;
  sfla_action_t     act_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SEG_W-1:0] seg_r;
  logic [CNT_W-1:0] pool_size_r;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic [LVL_W-1:0] active_r, active_nxt;
  logic [LVL_W-1:0] ptr_r, ptr_nxt;
  logic [LVL_W-1:0] end_r, end_nxt;
  sfla_status_t     status_r, status_nxt;

  logic             out_valid_r;
  logic [SEG_W-1:0] out_seg_r;
  logic             out_seg_valid_r;
  sfla_status_t     out_status_r;
  logic             out_last_r;
  logic [CNT_W-1:0] out_fc_r;

  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;
  stack_ctrl_t stack_c;
  lent_ctrl_t  lent_c;
  logic [SEG_W-1:0] stack_rd;
  logic        lent_bit;

  logic         in_accept;
  logic         out_free;
  logic         out_load;
  logic [SEG_W-1:0] ld_seg;
  logic         ld_seg_valid;
  sfla_status_t ld_status;
  logic         ld_last;
  logic         alloc_zero;
  logic         level_full;
  logic         free_ok;
  logic         is_last;
  logic [LVL_W-1:0] size_sat;

  sfla_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  sfla_stack u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (stack_c),
    .rd_data (stack_rd)
  );

  sfla_lent_map u_lent (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (lent_c),
    .rd_bit (lent_bit)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign alloc_zero = (act_r == ACT_ALLOC_MANY) && (cnt_r == '0);
  assign level_full = (level_r >= LVL_W'(POOL_DEPTH));
  assign free_ok    = alu_rsp.borrow && lent_bit && !level_full;
  assign is_last    = (alu_rsp.res == CNT_W'(end_r));

  // Saturate the requested pool size into 1..POOL_DEPTH
  always_comb begin
    if (pool_size_r == '0) begin
      size_sat = LVL_W'(1);
    end else if (pool_size_r > CNT_W'(POOL_DEPTH)) begin
      size_sat = LVL_W'(POOL_DEPTH);
    end else begin
      size_sat = LVL_W'(pool_size_r);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        case (act_r)
          ACT_ALLOC_ONE, ACT_ALLOC_MANY: begin
            state_nxt = (alu_rsp.borrow || alloc_zero) ? S_EMIT : S_SEND;
          end
          ACT_FREE: begin
            state_nxt = free_ok ? S_PUSH : S_EMIT;
          end
          default: state_nxt = S_EMIT;
        endcase
      end
      S_SEND: begin
        if (out_free && is_last) state_nxt = S_IDLE;
      end
      S_PUSH: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    alu_req      = '{a: CNT_W'(level_r), b: '0, sub: 1'b0};
    stack_c      = '0;
    lent_c       = '0;
    out_load     = 1'b0;
    ld_seg       = '0;
    ld_seg_valid = 1'b0;
    ld_status    = status_r;
    ld_last      = 1'b1;
    level_nxt    = level_r;
    active_nxt   = active_r;
    ptr_nxt      = ptr_r;
    end_nxt      = end_r;
    status_nxt   = status_r;
    case (state_r)
      S_EVAL: begin
        case (act_r)
          ACT_ALLOC_ONE, ACT_ALLOC_MANY: begin
            alu_req.sub = 1'b1;
            alu_req.b   = (act_r == ACT_ALLOC_ONE) ? CNT_W'(1) : cnt_r;
            if (alu_rsp.borrow) begin
              status_nxt = ST_SHORT;
            end else if (alloc_zero) begin
              status_nxt = ST_OK;
            end else begin
              // take the group now; results walk up from the deepest entry
              level_nxt       = LVL_W'(alu_rsp.res);
              ptr_nxt         = LVL_W'(alu_rsp.res);
              end_nxt         = level_r;
              stack_c.rd_en   = 1'b1;
              stack_c.rd_addr = IDX_W'(alu_rsp.res);
            end
          end
          ACT_FREE: begin
            alu_req.a  = CNT_W'(seg_r);
            alu_req.b  = CNT_W'(active_r);
            alu_req.sub = 1'b1;
            lent_c.idx = IDX_W'(seg_r);
            if (!alu_rsp.borrow) begin
              status_nxt = ST_RANGE;
            end else if (!lent_bit || level_full) begin
              status_nxt = ST_DOUBLE;
            end
          end
          default: begin
            active_nxt        = size_sat;
            level_nxt         = size_sat;
            stack_c.clear_all = 1'b1;
            lent_c.clear_all  = 1'b1;
            status_nxt        = ST_OK;
          end
        endcase
      end
      S_SEND: begin
        alu_req.a = CNT_W'(ptr_r);
        alu_req.b = CNT_W'(1);
        if (out_free) begin
          out_load      = 1'b1;
          ld_seg        = stack_rd;
          ld_seg_valid  = 1'b1;
          ld_status     = ST_OK;
          ld_last       = is_last;
          lent_c.set_en = 1'b1;
          lent_c.idx    = IDX_W'(stack_rd);
          if (!is_last) begin
            ptr_nxt         = LVL_W'(alu_rsp.res);
            stack_c.rd_en   = 1'b1;
            stack_c.rd_addr = IDX_W'(alu_rsp.res);
          end
        end
      end
      S_PUSH: begin
        alu_req.b       = CNT_W'(1);
        stack_c.wr_en   = 1'b1;
        stack_c.wr_addr = IDX_W'(level_r);
        stack_c.wr_data = seg_r;
        lent_c.clr_en   = 1'b1;
        lent_c.idx      = IDX_W'(seg_r);
        level_nxt       = LVL_W'(alu_rsp.res);
        status_nxt      = ST_OK;
      end
      S_EMIT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pool_size_r <= POOL_SIZE_RST;
      level_r     <= LVL_W'(POOL_DEPTH);
      active_r    <= LVL_W'(POOL_DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      level_r  <= level_nxt;
      active_r <= active_nxt;
      if (cfg_valid && cfg_ready) begin
        pool_size_r <= cfg_pool_size;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      act_r <= sfla_action_t'(in_action);
      cnt_r <= in_count;
      seg_r <= in_segment;
    end
    ptr_r    <= ptr_nxt;
    end_r    <= end_nxt;
    status_r <= status_nxt;
    if (out_load) begin
      out_seg_r       <= ld_seg;
      out_seg_valid_r <= ld_seg_valid;
      out_status_r    <= ld_status;
      out_last_r      <= ld_last;
      out_fc_r        <= CNT_W'(level_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_segment_out   = out_seg_r;
  assign out_segment_valid = out_seg_valid_r;
  assign out_status        = out_status_r;
  assign out_last          = out_last_r;
  assign out_free_count    = out_fc_r;

  a_level_le_active: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= active_r)
    else $error("free level exceeds active pool size");

  a_active_range: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r != '0) && (active_r <= LVL_W'(POOL_DEPTH)))
    else $error("active pool size out of range");

  a_send_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEND) |-> (ptr_r < end_r))
    else $error("allocation pointer ran past the group end");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH) |-> !level_full)
    else $error("push into a full stack");

  a_eval_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> $past(in_accept))
    else $error("evaluation without an input transaction");

endmodule

/* design/sfla_alu.sv */
// ----------------------------------------------------------------------------
// Segment allocator shared adder
// One add or subtract with borrow, reused by the evaluate, send and push steps.
// ----------------------------------------------------------------------------
module sfla_alu (
  input  sfla_pkg::alu_req_t req,
  output sfla_pkg::alu_rsp_t rsp
);
  import sfla_pkg::*;

  logic [CNT_W:0] wide;

  always_comb begin
    if (req.sub) begin
      wide = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      wide = {1'b0, req.a} + {1'b0, req.b};
    end
    rsp.res    = wide[CNT_W-1:0];
    rsp.borrow = req.sub & wide[CNT_W];
  end

endmodule

/* design/sfla_stack.sv */
// ----------------------------------------------------------------------------
// Segment allocator free stack
// Single-port-write memory with registered read. An entry not written since
// the last refill reads as its own index.
// ----------------------------------------------------------------------------
module sfla_stack (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sfla_pkg::stack_ctrl_t    ctrl,
  output logic [sfla_pkg::SEG_W-1:0] rd_data
);
  import sfla_pkg::*;

  logic [SEG_W-1:0]      mem [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] mark_r;
  logic [SEG_W-1:0]      rd_data_r;
  logic                  rd_mark_r;
  logic [IDX_W-1:0]      rd_addr_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= ctrl.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data_r <= mem[ctrl.rd_addr];
      rd_addr_r <= ctrl.rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r    <= '0;
      rd_mark_r <= 1'b0;
    end else begin
      if (ctrl.clear_all) begin
        mark_r <= '0;
      end else if (ctrl.wr_en) begin
        mark_r[ctrl.wr_addr] <= 1'b1;
      end
      if (ctrl.rd_en) begin
        rd_mark_r <= mark_r[ctrl.rd_addr];
      end
    end
  end

  assign rd_data = rd_mark_r ? rd_data_r : SEG_W'(rd_addr_r);

endmodule

/* design/sfla_lent_map.sv */
// ----------------------------------------------------------------------------
// Segment allocator lent map
// One flag per segment, set while the segment is handed out.
// ----------------------------------------------------------------------------
module sfla_lent_map (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sfla_pkg::lent_ctrl_t ctrl,
  output logic                 rd_bit
);
  import sfla_pkg::*;

  logic [POOL_DEPTH-1:0] lent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lent_r <= '0;
    end else if (ctrl.clear_all) begin
      lent_r <= '0;
    end else if (ctrl.set_en) begin
      lent_r[ctrl.idx] <= 1'b1;
    end else if (ctrl.clr_en) begin
      lent_r[ctrl.idx] <= 1'b0;
    end
  end

  assign rd_bit = lent_r[ctrl.idx];

endmodule
